FILE: rtl/core/hsec_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and geometry helpers for the Hamming SEC encoder/checker.
// No dependencies; used by hsec_syndrome and hamming_sec_encode_correct_top.
package hsec_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned SYN_W = 6;
  localparam int unsigned CNT_W = 5;
  localparam logic [CNT_W-1:0] DATA_BITS_RESET = 5'd26;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [SYN_W-1:0] syn_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_CHECK  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_FIXED = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  function automatic bit hsec_is_pow2(int unsigned p);
    return (p & (p - 1)) == 0;
  endfunction

  function automatic int unsigned hsec_chk(int unsigned n);
    int unsigned r;
    r = 1;
    for (int k = 0; k < 6; k++) begin
      if ((1 << r) < n + r + 1) begin
        r = r + 1;
      end
    end
    return r;
  endfunction

  // codeword length n+r for a count value, shrunk to fit the limit
  function automatic syn_t hsec_total(cnt_t cnt, int unsigned limit);
    int unsigned n;
    int unsigned r;
    int unsigned best;
    n = (cnt == '0) ? 1 : int'(cnt);
    r = hsec_chk(n);
    if (n + r > limit) begin
      best = 1;
      for (int m = 1; m < 32; m++) begin
        if (m + hsec_chk(m) <= limit) begin
          best = m;
        end
      end
      n = best;
      r = hsec_chk(n);
    end
    return SYN_W'(n + r);
  endfunction

endpackage

FILE: rtl/core/hsec_syndrome.sv
`timescale 1ns / 1ps
// Syndrome tree: XOR of the 1-based positions of all set bits of a word.
// Depends on hsec_pkg.
module hsec_syndrome
  import hsec_pkg::*;
(
  input  word_t word,
  output syn_t  syn
);

  always_comb begin
    syn = '0;
    for (int p = 1; p <= WORD_W; p++) begin
      for (int i = 0; i < SYN_W; i++) begin
        if (((p >> i) & 1) == 1) begin
          syn[i] = syn[i] ^ word[p-1];
        end
      end
    end
  end

endmodule

FILE: rtl/core/hamming_sec_encode_correct_top.sv
`timescale 1ns / 1ps
// Hamming SEC encoder/checker, three register stages: spread/mask, syndrome, fix-up.
// out_valid follows start through the s1, s2 and s3 valid registers; one beat accepted every cycle, busy stays low.
// The receiver cannot stall: each result shows for one cycle under out_valid.
// Synchronous active-low reset clears the stage valids and sets the codeword length for 26 data bits.
// Depends on hsec_pkg and hsec_syndrome.
module hamming_sec_encode_correct_top
  import hsec_pkg::*;
#(
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  cnt_t        cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  word_t       in_word_in,
  output logic        out_valid,
  output word_t       out_code_word,
  output syn_t        out_error_position,
  output logic [1:0]  out_error_status
);

  localparam int unsigned CODE_LIMIT = (MAX_CODE_BITS < WORD_W) ? MAX_CODE_BITS : WORD_W;

  syn_t  total_r;
  word_t mask_w;
  word_t spread_w;
  word_t s0_word_w;

  logic  s1_vld_r;
  mode_t s1_mode_r;
  word_t s1_word_r;

  logic  s2_vld_r;
  mode_t s2_mode_r;
  word_t s2_word_r;
  syn_t  s2_syn_r;
  syn_t  syn_w;

  word_t   code_nxt;
  syn_t    pos_nxt;
  status_t status_nxt;

  logic    s3_vld_r;
  word_t   s3_code_r;
  syn_t    s3_pos_r;
  status_t s3_status_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= hsec_total(DATA_BITS_RESET, CODE_LIMIT);
    end else if (cfg_we) begin
      total_r <= hsec_total(cfg_wdata, CODE_LIMIT);
    end
  end

  always_comb begin
    for (int p = 1; p <= WORD_W; p++) begin
      mask_w[p-1] = (p <= int'(total_r));
    end
  end

  // spread data bits over the non-power-of-two positions in order
  always_comb begin
    int d;
    d = 0;
    spread_w = '0;
    for (int p = 1; p <= WORD_W; p++) begin
      if (!hsec_is_pow2(p)) begin
        spread_w[p-1] = in_word_in[d];
        d = d + 1;
      end
    end
  end

  assign s0_word_w = ((in_mode == MODE_CHECK) ? in_word_in : spread_w) & mask_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_mode_r <= mode_t'(in_mode);
    s1_word_r <= s0_word_w;
  end

  hsec_syndrome u_syn (
    .word (s1_word_r),
    .syn  (syn_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_mode_r <= s1_mode_r;
    s2_word_r <= s1_word_r;
    s2_syn_r  <= syn_w;
  end

  always_comb begin
    code_nxt   = s2_word_r;
    pos_nxt    = '0;
    status_nxt = ST_NONE;
    if (s2_mode_r == MODE_ENCODE) begin
      for (int i = 0; i < SYN_W; i++) begin
        if ((1 << i) <= WORD_W) begin
          code_nxt[(1 << i) - 1] = s2_word_r[(1 << i) - 1] | s2_syn_r[i];
        end
      end
    end else begin
      pos_nxt = s2_syn_r;
      if (s2_syn_r == '0) begin
        status_nxt = ST_NONE;
      end else if (s2_syn_r <= total_r) begin
        code_nxt[5'(s2_syn_r - 6'd1)] = ~s2_word_r[5'(s2_syn_r - 6'd1)];
        status_nxt = ST_FIXED;
      end else begin
        status_nxt = ST_RANGE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_code_r   <= code_nxt;
    s3_pos_r    <= pos_nxt;
    s3_status_r <= status_nxt;
  end

  assign out_valid          = s3_vld_r;
  assign out_code_word      = s3_code_r;
  assign out_error_position = s3_pos_r;
  assign out_error_status   = s3_status_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("beat lost in pipeline");

  a_none_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && s3_status_r == ST_NONE) |-> (out_error_position == '0))
    else $error("clean status with nonzero syndrome");

  a_fixed_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && s3_status_r == ST_FIXED) |->
      (out_error_position != '0 && out_error_position <= total_r))
    else $error("corrected position outside codeword");

  a_range_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && s3_status_r == ST_RANGE) |-> (out_error_position > total_r))
    else $error("range flag with in-range syndrome");

  a_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_code_word & ~mask_w) == '0))
    else $error("codeword bits above length");
`endif

endmodule
